### rtl/core/sequence_track_event_parser_defines.svh
// Assertion macros for the sequence track event parser checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef SEQUENCE_TRACK_EVENT_PARSER_DEFINES_SVH
`define SEQUENCE_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("step checker: same-cycle rule violated");

// Next-cycle implication, disabled during reset.
`define STEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("step checker: next-cycle rule violated");

`endif

### rtl/core/step_pkg.sv
// Types and constants for the sequence track event parser.
// No dependencies.
package step_pkg;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_ONE      = 7'b0000010,
    PH_TWO_A    = 7'b0000100,
    PH_TWO_B    = 7'b0001000,
    PH_DELAY    = 7'b0010000,
    PH_TEMPO_LO = 7'b0100000,
    PH_TEMPO_HI = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    EV_CHANNEL = 2'd0,
    EV_END     = 2'd1,
    EV_TEMPO   = 2'd2
  } event_kind_t;

  localparam logic [7:0] CMD_DELAY    = 8'hF0;
  localparam logic [7:0] CMD_END      = 8'hF1;
  localparam logic [7:0] CMD_TEMPO    = 8'hF2;
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] TEMPO_LEN    = 8'h03;
  localparam logic [7:0] NOTE_OFF_VEL = 8'h40;
  localparam logic [7:0] BEND_BIAS    = 8'h40;

  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_PRES = 4'hA;
  localparam logic [3:0] NIB_CONTROL   = 4'hB;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
  localparam logic [3:0] NIB_BEND      = 4'hE;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;

  localparam int TEMPO_SHIFT = 11;  // times 2048

  typedef struct packed {
    event_kind_t event_kind;
    logic [31:0] event_tick;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [23:0] tempo_value;
  } result_t;

endpackage

### rtl/core/step_ifs.sv
// Valid/ready channel interfaces for track bytes in and MIDI events out.
// Depends on step_pkg.
interface step_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface step_out_if;
  import step_pkg::*;
  logic        valid;
  logic        ready;
  event_kind_t event_kind;
  logic [31:0] event_tick;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [23:0] tempo_value;

  modport source (output valid, output event_kind, output event_tick, output status_byte,
                  output first_data, output second_data, output tempo_value, input ready);
  modport sink   (input valid, input event_kind, input event_tick, input status_byte,
                  input first_data, input second_data, input tempo_value, output ready);
endinterface

### rtl/core/sequence_track_event_parser.sv
// Sequence track event parser: takes one track body byte per word and emits timed MIDI
// events (channel, end of track, tempo). Depends on step_pkg and step_ifs. A byte is taken
// every cycle unless stalled; each byte is decoded against the parser state and any event
// it completes appears on the output in the cycle after acceptance, held in a single output
// register. The input stalls only while that register holds an event not taken.
module sequence_track_event_parser (
  input logic        clk,
  input logic        rst,
  step_in_if.sink    in_ch,
  step_out_if.source out_ch
);
  import step_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  pending_command;
  logic [7:0]  pending_command_next;
  logic [7:0]  first_param;
  logic [7:0]  first_param_next;
  logic [31:0] tick_count;
  logic [31:0] tick_count_next;
  logic        track_ended;
  logic        track_ended_next;

  logic        out_valid;
  result_t     result;
  result_t     result_next;
  logic        emit;

  logic        accept;
  logic [31:0] tick_cur;
  logic        ended_cur;
  phase_t      phase_cur;
  logic [7:0]  b;
  logic [3:0]  cmd_nib;
  logic [3:0]  byte_nib;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign cmd_nib     = pending_command[7:4];
  assign byte_nib    = b[7:4];

  always_comb begin
    // track start clears tick, phase and end flag before the byte is decoded
    tick_cur  = in_ch.track_start ? '0 : tick_count;
    ended_cur = in_ch.track_start ? 1'b0 : track_ended;
    phase_cur = in_ch.track_start ? PH_IDLE : phase;

    phase_next           = phase_cur;
    pending_command_next = pending_command;
    first_param_next     = first_param;
    tick_count_next      = tick_cur;
    track_ended_next     = ended_cur;
    emit                 = 1'b0;

    result_next.event_kind  = EV_CHANNEL;
    result_next.event_tick  = tick_cur;
    result_next.status_byte = pending_command;
    result_next.first_data  = b;
    result_next.second_data = '0;
    result_next.tempo_value = '0;

    if (!ended_cur) begin
      unique case (phase_cur)
        PH_ONE: begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          if (cmd_nib == NIB_NOTE_OFF) begin
            result_next.second_data = NOTE_OFF_VEL;
          end else if (cmd_nib == NIB_BEND) begin
            result_next.first_data  = '0;
            result_next.second_data = b - BEND_BIAS;
          end
        end
        PH_TWO_A: begin
          first_param_next = b;
          phase_next       = PH_TWO_B;
        end
        PH_TWO_B: begin
          phase_next              = PH_IDLE;
          emit                    = 1'b1;
          result_next.first_data  = first_param;
          result_next.second_data = b;
        end
        PH_DELAY: begin
          tick_count_next = tick_cur + {24'd0, b};
          phase_next      = PH_IDLE;
        end
        PH_TEMPO_LO: begin
          first_param_next = b;
          phase_next       = PH_TEMPO_HI;
        end
        PH_TEMPO_HI: begin
          phase_next              = PH_IDLE;
          emit                    = 1'b1;
          result_next.event_kind  = EV_TEMPO;
          result_next.status_byte = META_STATUS;
          result_next.first_data  = META_TEMPO;
          result_next.second_data = TEMPO_LEN;
          // low 24 bits of the 16-bit tempo shifted up by eleven
          result_next.tempo_value = {b[4:0], first_param, {TEMPO_SHIFT{1'b0}}};
        end
        default: begin
          // idle: decode a command byte
          pending_command_next = b;
          phase_next           = PH_IDLE;
          unique case (byte_nib)
            NIB_NOTE_OFF, NIB_PROGRAM, NIB_CHAN_PRES, NIB_BEND: phase_next = PH_ONE;
            NIB_NOTE_ON, NIB_POLY_PRES, NIB_CONTROL:            phase_next = PH_TWO_A;
            NIB_SYSTEM: begin
              priority if (b == CMD_DELAY) begin
                phase_next = PH_DELAY;
              end else if (b == CMD_END) begin
                emit                    = 1'b1;
                track_ended_next        = 1'b1;
                result_next.event_kind  = EV_END;
                result_next.status_byte = META_STATUS;
                result_next.first_data  = META_END;
              end else if (b == CMD_TEMPO) begin
                phase_next = PH_TEMPO_LO;
              end else begin
                // unknown system command: skip
                phase_next = PH_IDLE;
              end
            end
            default: phase_next = PH_IDLE;  // data byte as command: skip
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      pending_command <= '0;
      first_param     <= '0;
      tick_count      <= '0;
      track_ended     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        pending_command <= pending_command_next;
        first_param     <= first_param_next;
        tick_count      <= tick_count_next;
        track_ended     <= track_ended_next;
        out_valid       <= emit;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the event until taken; a new one loads only on an accepted word
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= result_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.event_kind  = result.event_kind;
  assign out_ch.event_tick  = result.event_tick;
  assign out_ch.status_byte = result.status_byte;
  assign out_ch.first_data  = result.first_data;
  assign out_ch.second_data = result.second_data;
  assign out_ch.tempo_value = result.tempo_value;

endmodule

### rtl/core/step_checker.sv
// Port-level checks for the sequence track event parser, bound into every instance of it.
// Depends on step_pkg and sequence_track_event_parser_defines.svh.
`include "sequence_track_event_parser_defines.svh"

module step_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [7:0]            data_byte,
  input logic                  track_start,
  input logic                  out_valid,
  input logic                  out_ready,
  input step_pkg::event_kind_t event_kind,
  input logic [31:0]           event_tick,
  input logic [23:0]           tempo_value
);
  import step_pkg::*;

  // an empty output stage never stalls the input
  `STEP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // a stalled event holds
  `STEP_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(event_tick) && $stable(event_kind) && $stable(tempo_value))

  // end command right after a track start gives end of track at tick zero
  `STEP_ASSERT_NEXT(a_end_at_start, in_valid && in_ready && track_start && data_byte == CMD_END, out_valid && event_kind == EV_END && event_tick == 32'd0)

  // tempo values are multiples of 2048; other events carry no tempo
  `STEP_ASSERT_NOW(a_tempo_shape, out_valid, (event_kind == EV_TEMPO) ? (tempo_value[10:0] == 11'd0) : (tempo_value == 24'd0))

endmodule

bind sequence_track_event_parser step_checker u_step_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .data_byte   (in_ch.data_byte),
  .track_start (in_ch.track_start),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_kind  (out_ch.event_kind),
  .event_tick  (out_ch.event_tick),
  .tempo_value (out_ch.tempo_value)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sequence_track_event_parser: feeds track body bytes and
// scores every MIDI event against scripted expectations or an in-bench parser. Depends on step_pkg and step_ifs.
module tb_top;
  import step_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         typed;
    bit         fires;
    result_t    want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  step_in_if  in_ch();
  step_out_if out_ch();

  sequence_track_event_parser uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // parser state mirrored in the bench
  phase_t      phase_now    = PH_IDLE;
  logic [7:0]  command_held = 8'h00;
  logic [7:0]  param_held   = 8'h00;
  logic [31:0] tick_now     = 32'h0;
  bit          muted        = 1'b0;

  result_t     owed_events[$];
  script_row_t script[$];
  result_t     head_event;
  int          fail_count   = 0;
  int          bytes_taken  = 0;
  int          cycle_count  = 0;
  int          send_calm    = 0;
  int          sink_calm    = 0;
  bit          tail_phase   = 1'b0;
  bit          sender_steady = 1'b0;
  bit          sink_hold_req = 1'b0;

  // Advance the mirrored parser by one byte; returns 1 when an event completes.
  function automatic bit parse_byte(input logic [7:0] b, input logic s, output result_t ev,
                                    output bit heard);
    logic [23:0] tempo_word;
    ev = '0;
    heard = 1'b1;
    if (s) begin
      tick_now  = 32'h0;
      phase_now = PH_IDLE;
      muted     = 1'b0;
    end
    if (muted) begin
      heard = 1'b0;
      return 1'b0;
    end
    ev.event_tick = tick_now;
    case (phase_now)
      PH_ONE: begin
        phase_now = PH_IDLE;
        ev.event_kind  = EV_CHANNEL;
        ev.status_byte = command_held;
        case (command_held[7:4])
          NIB_NOTE_OFF: begin
            ev.first_data  = b;
            ev.second_data = NOTE_OFF_VEL;
          end
          NIB_BEND: begin
            ev.first_data  = 8'h00;
            ev.second_data = b - BEND_BIAS;
          end
          default: begin
            ev.first_data  = b;
            ev.second_data = 8'h00;
          end
        endcase
        return 1'b1;
      end
      PH_TWO_A: begin
        param_held = b;
        phase_now  = PH_TWO_B;
        return 1'b0;
      end
      PH_TWO_B: begin
        phase_now = PH_IDLE;
        ev.event_kind  = EV_CHANNEL;
        ev.status_byte = command_held;
        ev.first_data  = param_held;
        ev.second_data = b;
        return 1'b1;
      end
      PH_DELAY: begin
        tick_now  = tick_now + {24'h0, b};
        phase_now = PH_IDLE;
        return 1'b0;
      end
      PH_TEMPO_LO: begin
        param_held = b;
        phase_now  = PH_TEMPO_HI;
        return 1'b0;
      end
      PH_TEMPO_HI: begin
        phase_now  = PH_IDLE;
        tempo_word = {8'h00, b, param_held};
        ev.event_kind  = EV_TEMPO;
        ev.status_byte = META_STATUS;
        ev.first_data  = META_TEMPO;
        ev.second_data = TEMPO_LEN;
        ev.tempo_value = tempo_word << TEMPO_SHIFT;
        return 1'b1;
      end
      default: begin
        command_held = b;
        phase_now    = PH_IDLE;
        case (b[7:4])
          NIB_NOTE_OFF, NIB_PROGRAM, NIB_CHAN_PRES, NIB_BEND: phase_now = PH_ONE;
          NIB_NOTE_ON, NIB_POLY_PRES, NIB_CONTROL:            phase_now = PH_TWO_A;
          NIB_SYSTEM: begin
            if (b == CMD_DELAY) begin
              phase_now = PH_DELAY;
            end else if (b == CMD_TEMPO) begin
              phase_now = PH_TEMPO_LO;
            end else if (b == CMD_END) begin
              muted = 1'b1;
              ev.event_kind  = EV_END;
              ev.status_byte = META_STATUS;
              ev.first_data  = META_END;
              return 1'b1;
            end
          end
          default: phase_now = PH_IDLE;
        endcase
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic s, input bit typed,
                                  input bit fires, input result_t want);
    script_row_t row;
    row.data  = d;
    row.start = s;
    row.typed = typed;
    row.fires = fires;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Offer one word, hold it until taken, log the event it owes, then maybe idle.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed = 1'b0,
                           input bit fires = 1'b0, input result_t want = '0);
    result_t ev;
    bit      hit;
    bit      heard;
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.track_start <= s;
    do @(posedge clk); while (!in_ch.ready);
    hit = parse_byte(b, s, ev, heard);
    if (heard) bytes_taken++;
    if (typed) begin
      if (fires) owed_events.push_back(want);
    end else if (hit) begin
      owed_events.push_back(ev);
    end
    if (!tail_phase && !sender_steady) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        send_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 4) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [7:0] pick_param();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h40;
      3:       return 8'h7F;
      4:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_channel_message(input logic lead);
    logic [7:0] cmd;
    cmd = {4'($urandom_range(8, 14)), 4'($urandom)};
    send_byte(cmd, lead);
    if (cmd[7:4] == NIB_NOTE_ON || cmd[7:4] == NIB_POLY_PRES || cmd[7:4] == NIB_CONTROL)
      send_byte(pick_param(), 1'b0);
    send_byte(pick_param(), 1'b0);
  endtask

  task automatic send_random_message();
    int   pick;
    logic lead;
    // restart a muted track, and now and then a live one
    lead = muted || ($urandom_range(0, 29) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_channel_message(lead);
    end else if (pick < 65) begin
      send_byte(CMD_DELAY, lead);
      send_byte(pick_param(), 1'b0);
    end else if (pick < 73) begin
      send_byte(CMD_TEMPO, lead);
      send_byte(pick_param(), 1'b0);
      send_byte(pick_param(), 1'b0);
    end else if (pick < 80) begin
      if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(8'h00, 8'h7F)), lead);
      else send_byte(8'($urandom_range(8'hF3, 8'hFF)), lead);
    end else if (pick < 84) begin
      send_byte(CMD_END, lead);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
    end else begin
      // noise and cut-short sequences
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= 8'h00;
    in_ch.track_start <= 1'b0;

    add_row(CMD_END,   1'b1, 1'b1, 1'b1,
            result_t'{EV_END, 32'd0, META_STATUS, META_END, 8'h00, 24'h0});
    add_row(8'h90,     1'b0, 1'b1, 1'b0, '0);
    add_row(CMD_DELAY, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'hFF,     1'b0, 1'b1, 1'b0, '0);
    add_row(8'h90,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h7F,     1'b0, 1'b1, 1'b1,
            result_t'{EV_CHANNEL, 32'd255, 8'h90, 8'h00, 8'h7F, 24'h0});
    add_row(8'h8F,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h3C,     1'b0, 1'b1, 1'b1,
            result_t'{EV_CHANNEL, 32'd255, 8'h8F, 8'h3C, NOTE_OFF_VEL, 24'h0});
    add_row(8'hE0,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00,     1'b0, 1'b1, 1'b1,
            result_t'{EV_CHANNEL, 32'd255, 8'hE0, 8'h00, 8'hC0, 24'h0});
    add_row(8'hC5,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'hA1,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h12,     1'b0, 1'b0, 1'b0, '0);
    add_row(8'h34,     1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_TEMPO, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF,     1'b0, 1'b0, 1'b0, '0);
    // largest tempo overflows 24 bits
    add_row(8'hFF,     1'b0, 1'b1, 1'b1,
            result_t'{EV_TEMPO, 32'd255, META_STATUS, META_TEMPO, TEMPO_LEN, 24'hFFF800});
    add_row(8'h7F,     1'b0, 1'b1, 1'b0, '0);
    add_row(8'hFF,     1'b0, 1'b1, 1'b0, '0);
    add_row(8'h90,     1'b0, 1'b0, 1'b0, '0);
    // track start cuts the open note-on short
    add_row(CMD_END,   1'b1, 1'b1, 1'b1,
            result_t'{EV_END, 32'd0, META_STATUS, META_END, 8'h00, 24'h0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_byte(script[i].data, script[i].start, script[i].typed, script[i].fires,
                script[i].want);

    // hold the sender until every owed event is out
    in_ch.valid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);

    while (bytes_taken < 900) send_random_message();

    // stall the sink for a long stretch while words keep coming
    sink_hold_req = 1'b1;
    sender_steady = 1'b1;
    repeat (40) send_channel_message(muted);
    sender_steady = 1'b0;

    while (bytes_taken < 1500) send_random_message();
    tail_phase = 1'b1;
    while (bytes_taken < 1800) send_random_message();

    in_ch.valid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!tail_phase && sink_calm == 0 && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 59) == 0) sink_calm = $urandom_range(20, 80);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (owed_events.size() == 0) begin
        $error("unexpected event: kind %0d tick %0h status %0h", out_ch.event_kind,
               out_ch.event_tick, out_ch.status_byte);
        fail_count++;
      end else begin
        head_event = owed_events.pop_front();
        if (out_ch.event_kind !== head_event.event_kind) begin
          $error("event_kind: expected %0d, got %0d", head_event.event_kind,
                 out_ch.event_kind);
          fail_count++;
        end
        if (out_ch.event_tick !== head_event.event_tick) begin
          $error("event_tick: expected %0h, got %0h", head_event.event_tick,
                 out_ch.event_tick);
          fail_count++;
        end
        if (out_ch.status_byte !== head_event.status_byte) begin
          $error("status_byte: expected %0h, got %0h", head_event.status_byte,
                 out_ch.status_byte);
          fail_count++;
        end
        if (out_ch.first_data !== head_event.first_data) begin
          $error("first_data: expected %0h, got %0h", head_event.first_data,
                 out_ch.first_data);
          fail_count++;
        end
        if (out_ch.second_data !== head_event.second_data) begin
          $error("second_data: expected %0h, got %0h", head_event.second_data,
                 out_ch.second_data);
          fail_count++;
        end
        if (out_ch.tempo_value !== head_event.tempo_value) begin
          $error("tempo_value: expected %0h, got %0h", head_event.tempo_value,
                 out_ch.tempo_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
